// ===== sv/intel_hex_record_loader_defines.svh =====
// ----------------------------------------------------------------------------
// Intel HEX record loader assertion macros
// Shared concurrent assertion forms used by the loader top level.
// ----------------------------------------------------------------------------
`ifndef INTEL_HEX_RECORD_LOADER_DEFINES_SVH
`define INTEL_HEX_RECORD_LOADER_DEFINES_SVH

// Implication checked on every rising clock edge outside reset.
`define IHX_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define IHX_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/ihx_pkg.sv =====
// ----------------------------------------------------------------------------
// Intel HEX loader package
// Payload types, status codes, record types and command structs.
// ----------------------------------------------------------------------------
package ihx_pkg;

  localparam int unsigned MinLineChars = 11;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_MALFORMED = 3'd1,
    ST_CHECKSUM  = 3'd2,
    ST_FLASH     = 3'd3,
    ST_EOF       = 3'd4
  } status_e;

  typedef enum logic [7:0] {
    REC_DATA = 8'h00,
    REC_EOF  = 8'h01,
    REC_ESA  = 8'h02,
    REC_SSA  = 8'h03,
    REC_ELA  = 8'h04,
    REC_SLA  = 8'h05
  } rec_type_e;

  typedef enum logic [0:0] {
    REG_FLASH_BASE = 1'b0,
    REG_FLASH_SIZE = 1'b1
  } reg_index_e;

  localparam logic [7:0] CharColon = 8'h3A;

  typedef struct packed {
    logic        req_type;
    logic [7:0]  char_code;
    logic        line_end;
    logic [14:0] line_total;
  } in_item_t;

  typedef struct packed {
    logic        item_kind;
    logic [31:0] byte_address;
    logic [7:0]  data_byte;
    logic [2:0]  status;
    logic [2:0]  record_kind;
    logic        eof_seen;
    logic [31:0] lowest_address;
    logic [31:0] highest_address;
    logic [14:0] lines_accepted;
    logic        last;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;      // start request: clear bookkeeping
    logic take_char;  // absorb one character
    logic judge;      // evaluate the finished line
    logic load_data;  // load data-byte result for index
    logic load_stat;  // load the status result
    logic commit;     // apply line effects and clear line
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic emit_data;  // judged line emits data bytes
    logic last_byte;  // current byte index is the final one
  } dp_stat_t;

  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] v;
    v = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) v = {1'b0, c[3:0]};
    else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
      v = {1'b0, c[3:0] + 4'd9};
    return v;
  endfunction

endpackage

// ===== sv/ihx_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, one registered read port.
// ----------------------------------------------------------------------------
module ihx_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== sv/ihx_datapath.sv =====
// ----------------------------------------------------------------------------
// Intel HEX loader datapath
// Character decoding, line bookkeeping, checks and result formation.
// ----------------------------------------------------------------------------
module ihx_datapath import ihx_pkg::*; #(
  parameter int unsigned MaxDataBytes = 16,
  parameter int unsigned MaxLineChars = 43
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  in_item_t    in_i,
  input  dp_cmd_t     cmd_i,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_data_i,
  output dp_stat_t    stat_o,
  output out_item_t   out_o
);
  localparam int unsigned CntW = $clog2(MaxLineChars + 2);
  localparam int unsigned IdxW = (MaxDataBytes > 1) ? $clog2(MaxDataBytes) : 1;
  localparam int unsigned PosW = (CntW > 10) ? CntW : 10;

  logic [31:0] flash_base_q, flash_size_q;
  logic [CntW-1:0] char_count_q, char_count_d;
  logic [3:0]  high_nibble_q;
  logic        pending_q, line_error_q;
  logic [7:0]  byte_sum_q;
  logic [31:0] header_q;
  logic [31:0] base_addr_q, min_addr_q;
  logic [32:0] max_addr_q;
  logic [14:0] line_index_q, expected_q;
  logic        eof_q;
  logic [7:0]  addr_hi_q, addr_lo_q;

  // Judgment registers.
  status_e     st_q;
  logic [2:0]  kind_q;
  logic [32:0] start_q;
  logic [7:0]  n_q;
  logic [IdxW:0] idx_q;
  // Set while the pending status answers a start request rather than a line.
  logic        start_stat_q;

  // Character decode.
  logic [4:0]      hv;
  logic [3:0]      nib;
  logic [7:0]      byte_v;
  logic [PosW-1:0] pos, bi;
  logic            is_hex;

  always_comb begin
    hv     = hex_value(in_i.char_code);
    is_hex = !hv[4];
    nib    = is_hex ? hv[3:0] : 4'd0;
    byte_v = {high_nibble_q, nib};
    pos    = PosW'(char_count_q);
    bi     = (pos - PosW'(2)) >> 1;
    char_count_d = char_count_q;
    if (char_count_q < CntW'(MaxLineChars + 1)) char_count_d = char_count_q + 1'b1;
  end

  logic byte_done;
  assign byte_done = cmd_i.take_char && (char_count_q != '0) &&
                     (pos < PosW'(MaxLineChars)) && pending_q;

  logic          ram_we;
  logic [IdxW-1:0] ram_waddr;
  logic [7:0]    ram_rdata;
  assign ram_we    = byte_done && (bi >= PosW'(4)) && (bi - PosW'(4) < PosW'(MaxDataBytes));
  assign ram_waddr = IdxW'(bi - PosW'(4));

  ihx_ram #(.Width(8), .Depth(MaxDataBytes)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (byte_v),
    .raddr_i (idx_q[IdxW-1:0]),
    .rdata_o (ram_rdata)
  );

  // Line judgment.
  logic [7:0]  n_w, type_w;
  logic [15:0] off_w;
  logic [32:0] start_w, end_w, limit_w, max_new;
  logic [10:0] want_len;
  status_e     st_w;

  always_comb begin
    n_w     = header_q[31:24];
    off_w   = header_q[23:8];
    type_w  = header_q[7:0];
    want_len = 11'(MinLineChars) + {2'b0, n_w, 1'b0};
    start_w = {1'b0, base_addr_q} + {17'b0, off_w};
    end_w   = start_w + {25'b0, n_w};
    limit_w = {1'b0, flash_base_q} + {1'b0, flash_size_q};
    max_new = (end_w > max_addr_q) ? end_w : max_addr_q;
    if (char_count_q < CntW'(MinLineChars) || line_error_q ||
        n_w > 8'(MaxDataBytes) || 11'(char_count_q) != want_len || type_w > 8'd5)
      st_w = ST_MALFORMED;
    else if (byte_sum_q != 8'd0)
      st_w = ST_CHECKSUM;
    else if (type_w == REC_DATA)
      st_w = (max_new > limit_w) ? ST_FLASH : ST_OK;
    else if (type_w == REC_EOF)
      st_w = (expected_q == 15'd0 || line_index_q != expected_q - 15'd1) ? ST_EOF : ST_OK;
    else
      st_w = ST_OK;
  end

  assign stat_o.emit_data = (st_q == ST_OK) && (kind_q == 3'd0) && (n_q != 8'd0);
  assign stat_o.last_byte = (9'(idx_q) + 9'd1) >= {1'b0, n_q};

  // Only an accepted line advances the counter; a start status never does.
  logic        line_ok;
  logic [15:0] addr_v;
  assign line_ok = (st_q == ST_OK) && !start_stat_q;
  assign addr_v  = {(n_q > 8'd0) ? addr_hi_q : 8'd0, (n_q > 8'd1) ? addr_lo_q : 8'd0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flash_base_q <= '0;
      flash_size_q <= '0;
      char_count_q <= '0;
      high_nibble_q <= '0;
      pending_q    <= 1'b0;
      line_error_q <= 1'b0;
      byte_sum_q   <= '0;
      header_q     <= '0;
      base_addr_q  <= '0;
      min_addr_q   <= '1;
      max_addr_q   <= '0;
      line_index_q <= '0;
      expected_q   <= '0;
      eof_q        <= 1'b0;
      addr_hi_q    <= '0;
      addr_lo_q    <= '0;
      st_q         <= ST_OK;
      kind_q       <= '0;
      start_q      <= '0;
      n_q          <= '0;
      idx_q        <= '0;
      start_stat_q <= 1'b0;
      out_o        <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (reg_index_e'(cfg_index_i))
          REG_FLASH_BASE: flash_base_q <= cfg_data_i;
          REG_FLASH_SIZE: flash_size_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.start) begin
        base_addr_q  <= '0;
        min_addr_q   <= '1;
        max_addr_q   <= '0;
        line_index_q <= '0;
        eof_q        <= 1'b0;
        expected_q   <= in_i.line_total;
        char_count_q <= '0;
        high_nibble_q <= '0;
        pending_q    <= 1'b0;
        line_error_q <= 1'b0;
        byte_sum_q   <= '0;
        header_q     <= '0;
        addr_hi_q    <= '0;
        addr_lo_q    <= '0;
        st_q         <= ST_OK;
        kind_q       <= '0;
        start_stat_q <= 1'b1;
      end
      if (cmd_i.take_char) begin
        char_count_q <= char_count_d;
        if (char_count_q == '0) begin
          if (in_i.char_code != CharColon) line_error_q <= 1'b1;
        end else if (pos >= PosW'(MaxLineChars)) begin
          line_error_q <= 1'b1;
        end else begin
          if (!is_hex) line_error_q <= 1'b1;
          if (!pending_q) begin
            high_nibble_q <= nib;
            pending_q     <= 1'b1;
          end else begin
            pending_q  <= 1'b0;
            byte_sum_q <= byte_sum_q + byte_v;
            if (bi < PosW'(4)) begin
              header_q <= header_q | ({24'b0, byte_v} << (5'd8 * (5'd3 - 5'(bi))));
            end else if (bi == PosW'(4)) begin
              addr_hi_q <= byte_v;
            end else if (bi == PosW'(5) && MaxDataBytes > 1) begin
              addr_lo_q <= byte_v;
            end
          end
        end
      end
      if (cmd_i.judge) begin
        st_q    <= st_w;
        kind_q  <= (type_w <= 8'd5) ? type_w[2:0] : 3'd0;
        start_q <= start_w;
        n_q     <= n_w;
        idx_q   <= '0;
        start_stat_q <= 1'b0;
        if (st_w != ST_MALFORMED && st_w != ST_CHECKSUM && type_w == REC_DATA) begin
          max_addr_q <= max_new;
          if (start_w < {1'b0, min_addr_q}) min_addr_q <= start_w[31:0];
        end
      end
      if (cmd_i.load_data) begin
        out_o.item_kind       <= 1'b0;
        out_o.byte_address    <= start_q[31:0] + 32'(idx_q);
        out_o.data_byte       <= ram_rdata;
        out_o.status          <= ST_OK;
        out_o.record_kind     <= '0;
        out_o.eof_seen        <= 1'b0;
        out_o.lowest_address  <= '0;
        out_o.highest_address <= '0;
        out_o.lines_accepted  <= '0;
        out_o.last            <= 1'b0;
        idx_q <= idx_q + 1'b1;
      end
      if (cmd_i.commit) begin
        if (line_ok) begin
          line_index_q <= line_index_q + 15'd1;
          if (kind_q == 3'd1) eof_q <= 1'b1;
          if (kind_q == 3'd2 || kind_q == 3'd4) begin
            base_addr_q <= (kind_q == 3'd2) ? {12'b0, addr_v, 4'b0} : {addr_v, 16'b0};
          end
        end
        char_count_q <= '0;
        high_nibble_q <= '0;
        pending_q    <= 1'b0;
        line_error_q <= 1'b0;
        byte_sum_q   <= '0;
        header_q     <= '0;
        addr_hi_q    <= '0;
        addr_lo_q    <= '0;
      end
      if (cmd_i.load_stat) begin
        out_o.item_kind       <= 1'b1;
        out_o.byte_address    <= '0;
        out_o.data_byte       <= '0;
        out_o.status          <= st_q;
        out_o.record_kind     <= kind_q;
        out_o.eof_seen        <= eof_q || (line_ok && kind_q == 3'd1);
        out_o.lowest_address  <= min_addr_q;
        out_o.highest_address <= max_addr_q[32] ? 32'hFFFF_FFFF : max_addr_q[31:0];
        out_o.lines_accepted  <= line_ok ? line_index_q + 15'd1 : line_index_q;
        out_o.last            <= 1'b1;
      end
    end
  end
endmodule

// ===== sv/ihx_ctrl.sv =====
// ----------------------------------------------------------------------------
// Intel HEX loader controller
// Sequences character intake, line judgment and result transfers.
// ----------------------------------------------------------------------------
module ihx_ctrl import ihx_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  in_item_t in_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);
  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_JUDGE = 5'b00010,
    S_READ  = 5'b00100,
    S_DATA  = 5'b01000,
    S_STAT  = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   valid_q, valid_d;
  logic   fire, out_free;

  assign out_free    = !valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign fire        = in_valid_i && in_ready_o;
  assign out_valid_o = valid_q;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    valid_d = valid_q && !out_ready_i;
    unique case (state_q)
      S_IDLE: begin
        if (fire) begin
          if (in_i.req_type) begin
            cmd_o.start     = 1'b1;
            state_d         = S_STAT;
          end else begin
            cmd_o.take_char = 1'b1;
            if (in_i.line_end) state_d = S_JUDGE;
          end
        end
      end
      S_JUDGE: begin
        cmd_o.judge = 1'b1;
        state_d     = S_READ;
      end
      S_READ: begin
        state_d = stat_i.emit_data ? S_DATA : S_STAT;
      end
      S_DATA: begin
        if (out_free) begin
          cmd_o.load_data = 1'b1;
          valid_d         = 1'b1;
          state_d         = stat_i.last_byte ? S_STAT : S_READ;
        end
      end
      S_STAT: begin
        if (out_free) begin
          cmd_o.load_stat = 1'b1;
          cmd_o.commit    = 1'b1;
          valid_d         = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end
endmodule

// ===== sv/intel_hex_record_loader.sv =====
// ----------------------------------------------------------------------------
// Intel HEX record loader
// Parses Intel HEX text a character at a time and emits data bytes and status.
// ----------------------------------------------------------------------------
// Characters are taken only while the controller is idle. A character that ends a
// line is followed by a judgment state and a read of the line buffer RAM.
// A data line then alternates output loads with reads of the next byte until
// its last data byte and ends with the status load; any other line goes from the
// read straight to the status load. The single registered read port of the
// line buffer sets this order. A start request answers with one status
// transfer, loaded from the status state that follows it. The output
// register decouples the sides: a waiting result stalls only the next load,
// and each load waits for it to free up.
// Configuration writes land at once and must occur while the block is idle.
// Status results carry the bookkeeping state after the line; status values
// are ok, malformed, checksum bad, beyond flash and misplaced end of file.
`include "intel_hex_record_loader_defines.svh"
module intel_hex_record_loader import ihx_pkg::*; #(
  parameter int unsigned MaxDataBytes = 16,
  parameter int unsigned MaxLineChars = 43
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_item_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_item_t   out_data_o,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_data_i
);
  dp_cmd_t  cmd;
  dp_stat_t stat;

  // The controller sequences each transfer; the datapath holds the line and bookkeeping state.
  ihx_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_i        (in_data_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  ihx_datapath #(.MaxDataBytes(MaxDataBytes), .MaxLineChars(MaxLineChars)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_data_i),
    .cmd_i       (cmd),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .stat_o      (stat),
    .out_o       (out_data_o)
  );

  // A status result always marks the end of its run, and data results never do.
  `IHX_ASSERT_IMP(a_last_kind, clk_i, rst_ni, out_valid_o, out_data_o.last == out_data_o.item_kind, "last flag disagrees with item kind")
  // Data bytes are only produced for successful lines.
  `IHX_ASSERT_IMP(a_data_ok, clk_i, rst_ni, out_valid_o && !out_data_o.item_kind, out_data_o.status == ST_OK, "data result with error status")
  // A status load is never lost: it becomes a valid status result on the output.
  `IHX_ASSERT_NEXT(a_load_ready, clk_i, rst_ni, cmd.load_stat, out_valid_o && out_data_o.item_kind, "status load lost")
endmodule
